// ===== hw/rtl/cdau_pkg.sv =====
// ----------------------------------------------------------------------------
// cdau_pkg: shared types and constants of the calendar date arithmetic unit
// Day numbers count from 1201-01-01, the start of a 400-year cycle, so that
// the year walk lines up with whole cycles.
// ----------------------------------------------------------------------------
package cdau_pkg;

  localparam int NW          = 25;        // signed width of the walk registers
  localparam int BASE_YEAR   = 1201;
  localparam int EPOCH_YEAR  = 1582;
  localparam int EPOCH_N     = 139157;    // day number of 1582-01-01
  localparam int DIFF_MAX    = 4194303;
  localparam int DIFF_MIN    = -4194304;
  localparam int WALK_STEPS  = 17;
  localparam int MONTH_STEPS = 11;

  typedef logic signed [NW-1:0] num_t;
  typedef logic [4:0]           step_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SHIFT = 2'd1,
    OP_CMP   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Position of a year inside its 400-year cycle: centuries, 4-year groups
  // and single years counted by the walk.
  typedef struct packed {
    logic [1:0] cent;
    logic [4:0] quad;
    logic [1:0] yrs;
  } digits_t;

  // One trial subtract with conditional accumulate.
  typedef struct packed {
    num_t r;
    num_t a;
    num_t k;
    num_t c;
    logic force_take;
  } step_req_t;

  typedef struct packed {
    num_t r;
    num_t a;
    logic take;
  } step_rsp_t;

  // Walk schedule: 400-year chunks (binary, 32x down to 1x), up to three
  // centuries, 4-year chunks (16x down to 1x), up to three single years.
  function automatic num_t chunk_years(step_t i);
    step_t sh;
    num_t  v;
    sh = '0;
    case (i) inside
      [5'd0:5'd5]: begin
        sh = 5'd5 - i;
        v  = num_t'(400) << sh;
      end
      [5'd6:5'd8]:   v = num_t'(100);
      [5'd9:5'd13]: begin
        sh = 5'd13 - i;
        v  = num_t'(4) << sh;
      end
      default:       v = num_t'(1);
    endcase
    return v;
  endfunction

  function automatic num_t chunk_days(step_t i);
    step_t sh;
    num_t  v;
    sh = '0;
    case (i) inside
      [5'd0:5'd5]: begin
        sh = 5'd5 - i;
        v  = num_t'(146097) << sh;
      end
      [5'd6:5'd8]:   v = num_t'(36524);
      [5'd9:5'd13]: begin
        sh = 5'd13 - i;
        v  = num_t'(1461) << sh;
      end
      default:       v = num_t'(365);
    endcase
    return v;
  endfunction

  function automatic logic is_leap(digits_t d);
    return (d.yrs == 2'd3) && !((d.quad == 5'd24) && (d.cent != 2'd3));
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] v;
    case (m)
      4'd2:                      v = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   v = 5'd30;
      default:                   v = 5'd31;
    endcase
    return v;
  endfunction

  // days of the year before the first of month m
  function automatic logic [8:0] cum_days(logic [3:0] m, logic leap);
    logic [8:0] v;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

  // 8 = 1 mod 7: fold the octal digits, then fold the sum twice more
  function automatic logic [2:0] mod7(logic [NW-2:0] v);
    logic [5:0] s;
    logic [3:0] s2;
    logic [2:0] s3;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(v[3*i +: 3]);
    end
    s2 = 4'(s[5:3]) + 4'(s[2:0]);
    s3 = 3'(s2[3]) + s2[2:0];
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

// ===== hw/rtl/cdau_if.sv =====
// ----------------------------------------------------------------------------
// cdau_if: item channels of the calendar date arithmetic unit
// Valid/ready channels; an item moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface cdau_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [13:0]        given_year;
  logic [3:0]         given_month;
  logic [4:0]         given_day;
  logic signed [20:0] offset;

  modport source (output valid, op, given_year, given_month, given_day, offset,
                  input ready);
  modport sink   (input valid, op, given_year, given_month, given_day, offset,
                  output ready);
endinterface

interface cdau_out_if;
  logic               valid;
  logic               ready;
  logic [13:0]        cur_year;
  logic [3:0]         cur_month;
  logic [4:0]         cur_day;
  logic [2:0]         weekday;
  logic [8:0]         year_day;
  logic signed [22:0] difference;
  logic               limited;
  logic               bad_date;

  modport source (output valid, cur_year, cur_month, cur_day, weekday, year_day,
                  difference, limited, bad_date, input ready);
  modport sink   (input valid, cur_year, cur_month, cur_day, weekday, year_day,
                  difference, limited, bad_date, output ready);
endinterface

// ===== hw/rtl/cdau_step.sv =====
// ----------------------------------------------------------------------------
// cdau_step: shared trial-subtract and accumulate unit
// Takes when r - k is not negative (or when forced), then adds c to a.
// ----------------------------------------------------------------------------
module cdau_step
  import cdau_pkg::*;
(
  input  step_req_t req_i,
  output step_rsp_t rsp_o
);

  num_t diff;

  always_comb begin
    diff       = req_i.r - req_i.k;
    rsp_o.take = req_i.force_take | ~diff[NW-1];
    rsp_o.r    = rsp_o.take ? diff : req_i.r;
    rsp_o.a    = rsp_o.take ? (req_i.a + req_i.c) : req_i.a;
  end

endmodule

// ===== hw/rtl/calendar_date_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_unit: Gregorian date register with day arithmetic
// Holds one date from 1582-01-01 to MAX_YEAR-12-31; loads, shifts by a signed
// day count, or compares with a given date.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A load or compare runs the range check,
// year walk, day-of-month check and closing step; a shift runs the offset
// add, clamp, reverse year walk and month walk. A bad year or month or a
// day of zero on a load or compare, or op code 3, finishes straight after
// the check; a day past the end of its month is only found after the year
// walk. One trial-subtract unit does the work: a 17-step year walk (400,
// 100, 4 and 1 year chunks) turns a date into a day number or back, and a
// shift adds an 11-step month walk. A finished result waits in an output
// register, so the next item is accepted while it is still to be taken.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_unit
  import cdau_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cdau_in_if.sink           in_i,
  cdau_out_if.source        out_o
);

  // Day number (from 1201-01-01) of MAX_YEAR-12-31
  localparam int YEND   = MAX_YEAR + 1 - BASE_YEAR;
  localparam int LAST_N = 365 * YEND + YEND / 4 - YEND / 100 + YEND / 400 - 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CHECK  = 10'b00_0000_0010,  // range check, start of forward walk
    S_WALK   = 10'b00_0000_0100,  // year walk, either direction
    S_DOY    = 10'b00_0000_1000,  // day-in-month check, add day of year
    S_CLOSE  = 10'b00_0001_0000,  // commit load or form the difference
    S_SHIFT  = 10'b00_0010_0000,  // day number plus offset
    S_CLAMP  = 10'b00_0100_0000,  // clamp to range, start reverse walk
    S_MPREP  = 10'b00_1000_0000,  // year known, start month walk
    S_MONTH  = 10'b01_0000_0000,  // month walk
    S_FINISH = 10'b10_0000_0000   // hand result to the output register
  } state_e;

  state_e state_q, state_d;

  // latched item
  op_e                op_q;
  logic [13:0]        gy_q;
  logic [3:0]         gm_q;
  logic [4:0]         gd_q;
  logic signed [20:0] off_q;

  // walk registers
  num_t    r_q, r_d;
  num_t    a_q, a_d;
  digits_t dig_q, dig_d;
  step_t   step_q, step_d;
  logic    fwd_q, fwd_d;       // 1: date to day number
  logic    bad_q, bad_d;
  logic    lim_q, lim_d;
  logic [8:0] doy_g_q, doy_g_d;

  // current date and its cached day number and day of year
  logic [13:0]   year_q, year_d;
  logic [3:0]    month_q, month_d;
  logic [4:0]    day_q, day_d;
  logic [NW-2:0] ncur_q, ncur_d;
  logic [8:0]    doycur_q, doycur_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [2:0]         wd_q;
  logic [8:0]         yd_q;
  logic [13:0]        oy_q;
  logic [3:0]         om_q;
  logic [4:0]         od_q;
  logic signed [22:0] diff_q;
  logic               olim_q;
  logic               obad_q;
  logic               out_load;

  step_req_t req;
  step_rsp_t rsp;

  logic       in_fire;
  logic       range_ok;
  logic       leap;
  logic [8:0] cum;
  num_t       clamped;
  logic       lo_hit, hi_hit;
  logic signed [22:0] diff_sat;

  cdau_step u_step (
    .req_i (req),
    .rsp_o (rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign leap     = is_leap(dig_q);
  assign cum      = cum_days(gm_q, leap);
  assign range_ok = (gy_q >= 14'(EPOCH_YEAR)) && (gy_q <= 14'(MAX_YEAR)) &&
                    (gm_q >= 4'd1) && (gm_q <= 4'd12) && (gd_q != 5'd0);

  assign lo_hit  = (r_q < num_t'(EPOCH_N));
  assign hi_hit  = (r_q > num_t'(LAST_N));
  assign clamped = lo_hit ? num_t'(EPOCH_N) : (hi_hit ? num_t'(LAST_N) : r_q);

  always_comb begin
    if (r_q > num_t'(DIFF_MAX)) begin
      diff_sat = 23'(DIFF_MAX);
    end else if (r_q < num_t'(DIFF_MIN)) begin
      diff_sat = 23'(DIFF_MIN);
    end else begin
      diff_sat = r_q[22:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    r_d      = r_q;
    a_d      = a_q;
    dig_d    = dig_q;
    step_d   = step_q;
    fwd_d    = fwd_q;
    bad_d    = bad_q;
    lim_d    = lim_q;
    doy_g_d  = doy_g_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    ncur_d   = ncur_q;
    doycur_d = doycur_q;
    out_load = 1'b0;

    req.r          = r_q;
    req.a          = a_q;
    req.k          = '0;
    req.c          = '0;
    req.force_take = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          bad_d   = 1'b0;
          lim_d   = 1'b0;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (op_q == OP_SHIFT) begin
          state_d = S_SHIFT;
        end else if (op_q == OP_NONE) begin
          state_d = S_FINISH;
        end else if (!range_ok) begin
          bad_d   = 1'b1;
          state_d = S_FINISH;
        end else begin
          r_d     = num_t'(gy_q) - num_t'(BASE_YEAR);
          a_d     = '0;
          dig_d   = '0;
          step_d  = '0;
          fwd_d   = 1'b1;
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        // forward: key years, gather days; reverse: key days, gather years
        req.k  = fwd_q ? chunk_years(step_q) : chunk_days(step_q);
        req.c  = fwd_q ? chunk_days(step_q) : chunk_years(step_q);
        r_d    = rsp.r;
        a_d    = rsp.a;
        step_d = step_q + 5'd1;
        if (rsp.take) begin
          case (step_q) inside
            [5'd6:5'd8]:   dig_d.cent = dig_q.cent + 2'd1;
            [5'd9:5'd13]:  dig_d.quad = dig_q.quad | (5'd1 << (5'd13 - step_q));
            [5'd14:5'd16]: dig_d.yrs  = dig_q.yrs + 2'd1;
            default:       dig_d      = dig_q;
          endcase
        end
        if (step_q == 5'(WALK_STEPS - 1)) begin
          state_d = fwd_q ? S_DOY : S_MPREP;
        end
      end

      S_DOY: begin
        if (gd_q > month_len(gm_q, leap)) begin
          bad_d   = 1'b1;
          state_d = S_FINISH;
        end else begin
          req.c          = num_t'(cum) + num_t'(gd_q) - num_t'(1);
          req.force_take = 1'b1;
          a_d            = rsp.a;
          doy_g_d        = cum + 9'(gd_q);
          state_d        = S_CLOSE;
        end
      end

      S_CLOSE: begin
        if (op_q == OP_LOAD) begin
          year_d   = gy_q;
          month_d  = gm_q;
          day_d    = gd_q;
          ncur_d   = a_q[NW-2:0];
          doycur_d = doy_g_q;
        end else begin
          req.r          = $signed({1'b0, ncur_q});
          req.k          = a_q;
          req.force_take = 1'b1;
          r_d            = rsp.r;
        end
        state_d = S_FINISH;
      end

      S_SHIFT: begin
        req.r          = $signed({1'b0, ncur_q});
        req.k          = -num_t'(off_q);
        req.force_take = 1'b1;
        r_d            = rsp.r;
        state_d        = S_CLAMP;
      end

      S_CLAMP: begin
        lim_d   = lo_hit | hi_hit;
        r_d     = clamped;
        ncur_d  = clamped[NW-2:0];
        a_d     = '0;
        dig_d   = '0;
        step_d  = '0;
        fwd_d   = 1'b0;
        state_d = S_WALK;
      end

      S_MPREP: begin
        year_d   = 14'(BASE_YEAR) + a_q[13:0];
        doycur_d = r_q[8:0] + 9'd1;
        a_d      = '0;
        step_d   = '0;
        state_d  = S_MONTH;
      end

      S_MONTH: begin
        // a counts whole months passed; stalls once the month fits
        req.k  = num_t'(month_len(a_q[3:0] + 4'd1, leap));
        req.c  = num_t'(1);
        r_d    = rsp.r;
        a_d    = rsp.a;
        step_d = step_q + 5'd1;
        if (step_q == 5'(MONTH_STEPS - 1)) begin
          month_d = rsp.a[3:0] + 4'd1;
          day_d   = rsp.r[4:0] + 5'd1;
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      fwd_q       <= 1'b0;
      bad_q       <= 1'b0;
      lim_q       <= 1'b0;
      year_q      <= 14'(EPOCH_YEAR);
      month_q     <= 4'd1;
      day_q       <= 5'd1;
      ncur_q      <= (NW-1)'(EPOCH_N);
      doycur_q    <= 9'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      fwd_q       <= fwd_d;
      bad_q       <= bad_d;
      lim_q       <= lim_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
      ncur_q      <= ncur_d;
      doycur_q    <= doycur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item capture and walk datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(in_i.op);
      gy_q  <= in_i.given_year;
      gm_q  <= in_i.given_month;
      gd_q  <= in_i.given_day;
      off_q <= in_i.offset;
    end
    r_q     <= r_d;
    a_q     <= a_d;
    dig_q   <= dig_d;
    doy_g_q <= doy_g_d;
  end

  // output register; weekday is (N + 1) mod 7 with N counted from 1201
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oy_q   <= year_q;
      om_q   <= month_q;
      od_q   <= day_q;
      wd_q   <= mod7(ncur_q + (NW-1)'(1));
      yd_q   <= doycur_q;
      diff_q <= ((op_q == OP_CMP) && !bad_q) ? diff_sat : '0;
      olim_q <= lim_q;
      obad_q <= bad_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cur_year   = oy_q;
  assign out_o.cur_month  = om_q;
  assign out_o.cur_day    = od_q;
  assign out_o.weekday    = wd_q;
  assign out_o.year_day   = yd_q;
  assign out_o.difference = diff_q;
  assign out_o.limited    = olim_q;
  assign out_o.bad_date   = obad_q;

`ifndef SYNTHESIS
  // the held date never leaves the supported range
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (year_q >= 14'(EPOCH_YEAR)) && (year_q <= 14'(MAX_YEAR)) &&
    (month_q >= 4'd1) && (month_q <= 4'd12) && (day_q != 5'd0))
    else $error("current date out of range");

  // cached day number stays between the epoch and the last day
  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ncur_q >= (NW-1)'(EPOCH_N)) && (ncur_q <= (NW-1)'(LAST_N)))
    else $error("cached day number out of range");

  // only a shift can report clamping
  a_lim_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && lim_q |-> op_q == OP_SHIFT)
    else $error("limited flag on a non-shift item");
`endif

endmodule

// ===== tb/calendar_date_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_unit_tb: self-checking bench for the date unit
// Drives load, shift, compare and op code 3 items over valid/ready, keeps
// its own copy of the current date, and checks every result field by field.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_unit_tb
  import cdau_pkg::*;
();

  localparam int MAX_YR       = 9999;
  localparam int RANDOM_ITEMS = 750;
  localparam int HOLD_AT      = 200;   // receiver holds off here
  localparam int DRAIN_AT     = 400;   // sender waits for every result here
  localparam int CALM_FROM    = 650;   // no idling on either side from here
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;

  // One input item and one result item, at the block's widths.
  typedef struct packed {
    op_e                op;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [20:0] offset;
  } date_req_t;

  typedef struct packed {
    logic [13:0]        cur_year;
    logic [3:0]         cur_month;
    logic [4:0]         cur_day;
    logic [2:0]         weekday;
    logic [8:0]         year_day;
    logic signed [22:0] difference;
    logic               limited;
    logic               bad_date;
  } date_res_t;

  // Tracks the date the block should hold and the results still owed.
  // Day counts start at 0 for 1582-01-01, a Friday.
  class date_tracker;
    longint    y_now;
    int        m_now;
    int        d_now;
    date_res_t awaited[$];
    int        failures;

    function new();
      y_now    = 1582;
      m_now    = 1;
      d_now    = 1;
      failures = 0;
    endfunction

    static function bit leap_year(longint y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int month_days(longint y, int m);
      case (m)
        2:           return leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    static function longint leaps_through(longint y);
      return y / 4 - y / 100 + y / 400;
    endfunction

    static function longint jan_first(longint y);
      return 365 * (y - 1582) + leaps_through(y - 1) - leaps_through(1581);
    endfunction

    static function int ordinal(longint y, int m, int d);
      int s;
      s = 0;
      for (int i = 1; i < m; i++) s += month_days(y, i);
      return s + d;
    endfunction

    static function longint day_count(longint y, int m, int d);
      return jan_first(y) + ordinal(y, m, d) - 1;
    endfunction

    static function bit real_date(longint y, int m, int d);
      if (y < 1582 || y > MAX_YR || m < 1 || m > 12 || d < 1) return 1'b0;
      return d <= month_days(y, m);
    endfunction

    function void move_to(longint n);
      longint y;
      longint r;
      int     m;
      y = 1582 + n / 366;
      while (jan_first(y + 1) <= n) y++;
      r = n - jan_first(y);
      m = 1;
      while (m < 12 && r >= month_days(y, m)) begin
        r -= month_days(y, m);
        m++;
      end
      y_now = y;
      m_now = m;
      d_now = int'(r) + 1;
    endfunction

    function void note_item(date_req_t it);
      date_res_t want;
      longint    n;
      longint    last_n;
      longint    diff;
      bit        ok;
      want = '0;
      diff = 0;
      ok   = real_date(it.year, it.month, it.day);
      case (it.op)
        OP_LOAD: begin
          if (ok) begin
            y_now = it.year;
            m_now = it.month;
            d_now = it.day;
          end else begin
            want.bad_date = 1'b1;
          end
        end
        OP_SHIFT: begin
          last_n = jan_first(MAX_YR + 1) - 1;
          n = day_count(y_now, m_now, d_now) + longint'(it.offset);
          if (n < 0) begin
            n = 0;
            want.limited = 1'b1;
          end else if (n > last_n) begin
            n = last_n;
            want.limited = 1'b1;
          end
          move_to(n);
        end
        OP_CMP: begin
          if (ok) begin
            diff = day_count(y_now, m_now, d_now) - day_count(it.year, it.month, it.day);
            if (diff > DIFF_MAX) diff = DIFF_MAX;
            if (diff < DIFF_MIN) diff = DIFF_MIN;
          end else begin
            want.bad_date = 1'b1;
          end
        end
        default: ;  // unused code: nothing moves
      endcase
      n = day_count(y_now, m_now, d_now);
      want.cur_year   = 14'(y_now);
      want.cur_month  = 4'(m_now);
      want.cur_day    = 5'(d_now);
      want.weekday    = 3'((n + 5) % 7);
      want.year_day   = 9'(ordinal(y_now, m_now, d_now));
      want.difference = 23'(diff);
      awaited = {awaited, want};
    endfunction

    function void compare_field(string name, longint want, longint seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        failures++;
      end
    endfunction

    function void check_result(date_res_t seen);
      date_res_t want;
      if (awaited.size() == 0) begin
        $error("result item with no input item waiting for it");
        failures++;
        return;
      end
      want = awaited.pop_front();
      compare_field("cur_year",   want.cur_year,   seen.cur_year);
      compare_field("cur_month",  want.cur_month,  seen.cur_month);
      compare_field("cur_day",    want.cur_day,    seen.cur_day);
      compare_field("weekday",    want.weekday,    seen.weekday);
      compare_field("year_day",   want.year_day,   seen.year_day);
      compare_field("difference", want.difference, seen.difference);
      compare_field("limited",    want.limited,    seen.limited);
      compare_field("bad_date",   want.bad_date,   seen.bad_date);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cdau_in_if  in_if ();
  cdau_out_if out_if ();

  calendar_date_arithmetic_unit #(
    .MAX_YEAR(MAX_YR)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #6 clk_i = ~clk_i;

  date_tracker dates;

  // Sender-to-receiver requests, written only by the sender and only with
  // nonblocking assignments, so the receiver sees them at the next edge.
  int hold_ask = 0;
  bit calm     = 1'b0;

  // Receiver: checks each taken item, then picks ready for the next edge.
  // A long hold-off is counted here, so the sender keeps pushing into a
  // block whose output register and working slot both fill up.
  always @(posedge clk_i) begin : sink_side
    date_res_t got;
    int        stall_left;
    int        hold_seen;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.cur_year   = out_if.cur_year;
        got.cur_month  = out_if.cur_month;
        got.cur_day    = out_if.cur_day;
        got.weekday    = out_if.weekday;
        got.year_day   = out_if.year_day;
        got.difference = out_if.difference;
        got.limited    = out_if.limited;
        got.bad_date   = out_if.bad_date;
        dates.check_result(got);
      end
      if (hold_seen != hold_ask) begin
        hold_seen  = hold_ask;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        // random burst with ready low, starting with this cycle
        stall_left = $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  // Present one item and hold it until the block takes it. Valid is left
  // high so a following item goes out back to back.
  task automatic send_item(date_req_t it);
    in_if.valid       <= 1'b1;
    in_if.op          <= it.op;
    in_if.given_year  <= it.year;
    in_if.given_month <= it.month;
    in_if.given_day   <= it.day;
    in_if.offset      <= it.offset;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    dates.note_item(it);
  endtask

  task automatic idle_gap(int n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_idle(bit quiet);
    if (!quiet && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 5));
  endtask

  task automatic send_fields(op_e op, int y, int m, int d, int off);
    date_req_t it;
    it.op     = op;
    it.year   = 14'(y);
    it.month  = 4'(m);
    it.day    = 5'(d);
    it.offset = 21'(off);
    maybe_idle(1'b0);
    send_item(it);
  endtask

  // Mostly real dates with random content; some raw noise and some dates
  // with a day past the end of the month, a day of zero or a bad month.
  function automatic date_req_t make_item();
    date_req_t it;
    int        pick;
    int        y;
    int        m;
    int        mag;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      0:                 it.op = OP_NONE;
      1, 2, 3, 4, 5, 6:  it.op = OP_LOAD;
      7, 8, 9, 10, 11:   it.op = OP_CMP;
      default:           it.op = OP_SHIFT;
    endcase
    case ($urandom_range(0, 4))
      0:       y = $urandom_range(0, 1) ? $urandom_range(1582, 1605)
                                         : $urandom_range(MAX_YR - 20, MAX_YR);
      1:       y = $urandom_range(1582, MAX_YR);
      default: y = $urandom_range(1582, 2500);
    endcase
    m         = $urandom_range(1, 12);
    it.year   = 14'(y);
    it.month  = 4'(m);
    it.day    = 5'($urandom_range(1, date_tracker::month_days(y, m)));
    // raw offset over all bits, or a signed magnitude of some size
    it.offset = 21'($urandom);
    case ($urandom_range(0, 19))
      0, 1:          mag = -1;
      2, 3, 4:       mag = $urandom_range(0, 400000);
      5, 6, 7, 8, 9: mag = $urandom_range(0, 3000);
      default:       mag = $urandom_range(0, 60);
    endcase
    if (mag >= 0) it.offset = 21'($urandom_range(0, 1) ? mag : -mag);
    if (pick < 8) begin
      // raw noise over every bit of every field
      it.op     = op_e'($urandom_range(0, 3));
      it.year   = 14'($urandom);
      it.month  = 4'($urandom);
      it.day    = 5'($urandom);
      it.offset = 21'($urandom);
    end else if (pick < 15) begin
      // broken date: a day past the month, day zero, or a bad month
      case ($urandom_range(0, 2))
        0:       it.day   = 5'($urandom_range(date_tracker::month_days(y, m) + 1, 32) % 32);
        1:       it.day   = 5'd0;
        default: it.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
      endcase
    end
    return it;
  endfunction

  initial begin : stimulus
    int gap_free;
    bit quiet;
    dates = new();
    in_if.valid       <= 1'b0;
    in_if.op          <= OP_LOAD;
    in_if.given_year  <= '0;
    in_if.given_month <= '0;
    in_if.given_day   <= '0;
    in_if.offset      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: unused code, clamps at both ends, offset extremes, dates
    // that are not real, century leap rules and a year wrap into a leap year.
    send_fields(OP_NONE,  0, 0, 0, 0);
    send_fields(OP_SHIFT, 0, 0, 0, -1);
    send_fields(OP_CMP,   1582, 1, 1, 0);
    send_fields(OP_LOAD,  MAX_YR, 12, 31, 0);
    send_fields(OP_SHIFT, 0, 0, 0, 1);
    send_fields(OP_CMP,   1582, 1, 1, 0);
    send_fields(OP_SHIFT, 0, 0, 0, -1048576);
    send_fields(OP_SHIFT, 0, 0, 0, 1048575);
    send_fields(OP_LOAD,  1581, 12, 31, 0);
    send_fields(OP_LOAD,  MAX_YR + 1, 1, 1, 0);
    send_fields(OP_LOAD,  16383, 15, 31, 0);
    send_fields(OP_LOAD,  2000, 0, 10, 0);
    send_fields(OP_LOAD,  2000, 13, 1, 0);
    send_fields(OP_LOAD,  2000, 4, 0, 0);
    send_fields(OP_LOAD,  2001, 4, 31, 0);
    send_fields(OP_LOAD,  1700, 2, 29, 0);
    send_fields(OP_LOAD,  1600, 2, 29, 0);
    send_fields(OP_CMP,   MAX_YR, 12, 31, 0);
    send_fields(OP_CMP,   2100, 2, 29, 0);
    send_fields(OP_LOAD,  2023, 12, 31, 0);
    send_fields(OP_SHIFT, 0, 0, 0, 60);
    send_fields(OP_LOAD,  1999, 12, 31, 0);
    send_fields(OP_SHIFT, 0, 0, 0, 366);
    send_fields(OP_CMP,   2000, 2, 29, 0);
    send_fields(OP_NONE,  16383, 15, 31, -1);

    gap_free = 0;
    quiet    = 1'b0;
    for (int i = 1; i <= RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) begin
        // receiver stops taking; keep offering so the input backs up
        hold_ask <= hold_ask + 1;
        gap_free = 30;
      end
      if (i == DRAIN_AT) begin
        idle_gap(1);
        while (dates.pending() != 0) @(posedge clk_i);
      end
      if (i == CALM_FROM) begin
        calm  <= 1'b1;
        quiet = 1'b1;
      end
      if (gap_free > 0) gap_free--;
      maybe_idle(quiet || gap_free > 0);
      send_item(make_item());
    end

    idle_gap(1);
    while (dates.pending() != 0) @(posedge clk_i);
    // anything arriving now has no item behind it and is flagged
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (dates.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cdau_pkg.sv
hw/rtl/cdau_if.sv
hw/rtl/cdau_step.sv
hw/rtl/calendar_date_arithmetic_unit.sv
tb/calendar_date_arithmetic_unit_tb.sv
